@@ src/escape_sequence_trie_matcher_defines.svh @@
// Assertion macros used by the matcher back end.
`ifndef ESCAPE_SEQUENCE_TRIE_MATCHER_DEFINES_SVH
`define ESCAPE_SEQUENCE_TRIE_MATCHER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define ESTM_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("matcher check failed");

// Condition implies consequence in the next cycle.
`define ESTM_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("matcher check failed");

`endif

@@ src/estm_pkg.sv @@
// Shared types and constants of the escape-sequence trie matcher.
package estm_pkg;

  localparam int NODES_DEF   = 256;
  localparam int MAX_SEQ_DEF = 16;
  localparam int MIN_SEQ     = 2;

  localparam logic [15:0] NUL_EXTRA_A = 16'd1;
  localparam logic [15:0] NUL_EXTRA_B = 16'd32;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_BYTE    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_RAW    = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_ADDED  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD_BYTE = 2'd0,
    OP_ADD_LAST = 2'd1,
    OP_BYTE     = 2'd2,
    OP_TIMEOUT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] key;
  } item_t;

endpackage

@@ src/estm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module estm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/estm_front.sv @@
// Front end: takes input beats, classifies them and queues them for the engine.
module estm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 in_tlast,
  output estm_pkg::item_t      item,
  output logic                 item_valid,
  input  logic                 item_ready
);

  estm_pkg::item_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  estm_pkg::item_t cls;
  logic            keep;
  logic            push;
  logic            pop;

  // Unused mode codes are accepted and dropped here.
  always_comb begin
    cls.data = in_tdata[7:0];
    cls.key  = in_tdata[23:8];
    keep     = 1'b1;
    unique case (in_tuser)
      estm_pkg::MODE_ADD: begin
        cls.op = in_tlast ? estm_pkg::OP_ADD_LAST : estm_pkg::OP_ADD_BYTE;
      end
      estm_pkg::MODE_BYTE:    cls.op = estm_pkg::OP_BYTE;
      estm_pkg::MODE_TIMEOUT: cls.op = estm_pkg::OP_TIMEOUT;
      default: begin
        cls.op = estm_pkg::OP_TIMEOUT;
        keep   = 1'b0;
      end
    endcase
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready && keep;
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/estm_back.sv @@
// Back end: trie walk, insertion and result output register.
`include "escape_sequence_trie_matcher_defines.svh"

module estm_back #(
  parameter int NODES   = estm_pkg::NODES_DEF,
  parameter int MAX_SEQ = estm_pkg::MAX_SEQ_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  estm_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  localparam int AW = $clog2(NODES);
  localparam int UW = $clog2(NODES + 1);
  localparam int LW = $clog2(MAX_SEQ + 2);
  localparam int PW = $clog2(MAX_SEQ);
  localparam int CW = LW + UW;
  localparam int NW = 26 + 2 * AW;
  localparam int SIB_LO = 26;
  localparam int KID_LO = 26 + AW;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_ADD_RD   = 11'b00000000100,
    S_ADD_CMP  = 11'b00000001000,
    S_ADD_FIN  = 11'b00000010000,
    S_APP_NEW  = 11'b00000100000,
    S_APP_LINK = 11'b00001000000,
    S_PFX_CHK  = 11'b00010000000,
    S_BYTE_RD  = 11'b00100000000,
    S_BYTE_CMP = 11'b01000000000,
    S_EMIT     = 11'b10000000000
  } state_t;

  state_t        state_r;
  logic [7:0]    pend_r [MAX_SEQ];
  logic [LW-1:0] len_r;
  logic [LW-1:0] pos_r;
  logic [UW-1:0] used_r;
  logic [7:0]    clr_r;
  logic          matching_r;
  logic [AW-1:0] match_r;
  logic [AW-1:0] cur_r;
  logic [AW-1:0] lastm_r;
  logic [NW-1:0] cur_data_r;
  logic [NW-1:0] last_data_r;
  logic          first_r;
  logic          grow_r;
  logic          link_sib_r;
  logic [7:0]    byte_r;
  logic [15:0]   key_r;
  logic [1:0]    kind_r [3];
  logic [15:0]   val_r  [3];
  logic [1:0]    cnt_r;
  logic [1:0]    idx_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;

  logic [NW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [NW-1:0] wdata;
  logic [7:0]    pend_sel;
  logic [NW-1:0] new_node;
  logic [NW-1:0] linked;
  logic [NW-1:0] trunc;
  logic [LW-1:0] new_len;
  logic          add_bad;
  logic          no_room;
  logic          out_free;
  logic          pos_full;
  logic          pfx_we;
  logic [7:0]    pfx_waddr;
  logic [0:0]    pfx_wdata;
  logic [0:0]    pfx_rdata;

  assign pend_sel = pend_r[pos_r[PW-1:0]];
  assign new_node = {{(2 * AW + 2){1'b0}}, key_r, pend_sel};
  assign new_len  = len_r + LW'(len_r <= LW'(MAX_SEQ));
  assign add_bad  = (new_len < LW'(estm_pkg::MIN_SEQ)) || (new_len > LW'(MAX_SEQ));
  assign no_room  = CW'(len_r - pos_r) > CW'(UW'(NODES) - used_r);
  assign out_free = !out_valid_r || out_tready;
  assign pos_full = (pos_r == len_r);

  always_comb begin
    linked = cur_data_r;
    if (link_sib_r) begin
      linked[24]                = 1'b1;
      linked[SIB_LO +: AW]      = used_r[AW-1:0];
    end else begin
      linked[25]                = 1'b1;
      linked[KID_LO +: AW]      = used_r[AW-1:0];
    end
    trunc               = last_data_r;
    trunc[23:8]         = key_r;
    trunc[25]           = 1'b0;
    trunc[KID_LO +: AW] = '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = linked;
    unique case (state_r)
      S_ADD_FIN: begin
        we    = pos_full;
        waddr = lastm_r;
        wdata = trunc;
      end
      S_APP_NEW: begin
        we    = 1'b1;
        waddr = used_r[AW-1:0];
        wdata = new_node;
      end
      S_APP_LINK: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  estm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_r),
    .rdata (rdata)
  );

  // Prefix marks: cleared by a pass over all 256 entries after reset, then set
  // when a sequence opens a new top-level branch.
  always_comb begin
    pfx_we    = 1'b0;
    pfx_waddr = pend_sel;
    pfx_wdata = 1'b1;
    if (state_r == S_CLEAR) begin
      pfx_we    = 1'b1;
      pfx_waddr = clr_r;
      pfx_wdata = 1'b0;
    end else if (state_r == S_ADD_FIN && !pos_full && !no_room && first_r) begin
      pfx_we = 1'b1;
    end
  end

  estm_ram #(.WIDTH(1), .DEPTH(256)) u_prefix (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (pfx_waddr),
    .wdata (pfx_wdata),
    .raddr (item.data),
    .rdata (pfx_rdata)
  );

  assign item_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      len_r       <= '0;
      pos_r       <= '0;
      used_r      <= '0;
      clr_r       <= '0;
      matching_r  <= 1'b0;
      match_r     <= '0;
      cur_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == 8'hFF) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            byte_r <= item.data;
            key_r  <= item.key;
            idx_r  <= '0;
            unique case (item.op)
              estm_pkg::OP_ADD_BYTE, estm_pkg::OP_ADD_LAST: begin
                if (len_r < LW'(MAX_SEQ)) begin
                  pend_r[len_r[PW-1:0]] <= item.data;
                end
                len_r <= (item.op == estm_pkg::OP_ADD_LAST && add_bad) ? '0 : new_len;
                if (item.op == estm_pkg::OP_ADD_LAST) begin
                  pos_r   <= '0;
                  cur_r   <= '0;
                  first_r <= 1'b1;
                  grow_r  <= 1'b0;
                  if (add_bad) begin
                    kind_r[0] <= estm_pkg::KIND_REJECT;
                    val_r[0]  <= '0;
                    cnt_r     <= 2'd1;
                    state_r   <= S_EMIT;
                  end else if (used_r != '0) begin
                    state_r <= S_ADD_RD;
                  end else begin
                    state_r <= S_ADD_FIN;
                  end
                end
              end
              estm_pkg::OP_BYTE: begin
                kind_r[0] <= estm_pkg::KIND_RAW;
                val_r[0]  <= {8'd0, item.data};
                cnt_r     <= 2'd1;
                if (matching_r) begin
                  cur_r   <= match_r;
                  state_r <= S_BYTE_RD;
                end else begin
                  state_r <= S_PFX_CHK;
                end
              end
              estm_pkg::OP_TIMEOUT: begin
                matching_r <= 1'b0;
                match_r    <= '0;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_PFX_CHK: begin
          if (!pfx_rdata[0]) begin
            // An unmarked zero byte carries two extra raw results.
            if (byte_r == 8'd0) begin
              kind_r[1] <= estm_pkg::KIND_RAW;
              val_r[1]  <= estm_pkg::NUL_EXTRA_A;
              kind_r[2] <= estm_pkg::KIND_RAW;
              val_r[2]  <= estm_pkg::NUL_EXTRA_B;
              cnt_r     <= 2'd3;
            end
            state_r <= S_EMIT;
          end else if (used_r == '0) begin
            state_r <= S_EMIT;
          end else begin
            cur_r   <= '0;
            state_r <= S_BYTE_RD;
          end
        end
        S_ADD_RD: state_r <= S_ADD_CMP;
        S_ADD_CMP: begin
          cur_data_r <= rdata;
          if (pend_sel == rdata[7:0]) begin
            first_r     <= 1'b0;
            lastm_r     <= cur_r;
            last_data_r <= rdata;
            pos_r       <= pos_r + 1'b1;
            if (rdata[25]) begin
              cur_r   <= rdata[KID_LO +: AW];
              state_r <= (pos_r + 1'b1 == len_r) ? S_ADD_FIN : S_ADD_RD;
            end else begin
              grow_r  <= 1'b1;
              state_r <= S_ADD_FIN;
            end
          end else if (rdata[24]) begin
            cur_r   <= rdata[SIB_LO +: AW];
            state_r <= S_ADD_RD;
          end else begin
            state_r <= S_ADD_FIN;
          end
        end
        S_ADD_FIN: begin
          val_r[0] <= '0;
          cnt_r    <= 2'd1;
          if (pos_full) begin
            kind_r[0]  <= estm_pkg::KIND_ADDED;
            matching_r <= 1'b0;
            match_r    <= '0;
            len_r      <= '0;
            state_r    <= S_EMIT;
          end else if (no_room) begin
            kind_r[0] <= estm_pkg::KIND_REJECT;
            len_r     <= '0;
            state_r   <= S_EMIT;
          end else begin
            link_sib_r <= !grow_r;
            state_r    <= S_APP_NEW;
          end
        end
        S_APP_NEW, S_APP_LINK: begin
          if (state_r == S_APP_NEW && used_r != '0) begin
            state_r <= S_APP_LINK;
          end else begin
            cur_r      <= used_r[AW-1:0];
            cur_data_r <= new_node;
            used_r     <= used_r + 1'b1;
            pos_r      <= pos_r + 1'b1;
            link_sib_r <= 1'b0;
            if (pos_r + 1'b1 == len_r) begin
              kind_r[0]  <= estm_pkg::KIND_ADDED;
              matching_r <= 1'b0;
              match_r    <= '0;
              len_r      <= '0;
              state_r    <= S_EMIT;
            end else begin
              state_r <= S_APP_NEW;
            end
          end
        end
        S_BYTE_RD: state_r <= S_BYTE_CMP;
        S_BYTE_CMP: begin
          if (rdata[7:0] == byte_r) begin
            if (rdata[25]) begin
              matching_r <= 1'b1;
              match_r    <= rdata[KID_LO +: AW];
            end else begin
              kind_r[1]  <= estm_pkg::KIND_KEY;
              val_r[1]   <= rdata[23:8];
              cnt_r      <= 2'd2;
              matching_r <= 1'b0;
              match_r    <= '0;
            end
            state_r <= S_EMIT;
          end else if (rdata[24]) begin
            cur_r   <= rdata[SIB_LO +: AW];
            state_r <= S_BYTE_RD;
          end else begin
            matching_r <= 1'b0;
            match_r    <= '0;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r[idx_r];
            out_data_r  <= val_r[idx_r];
            out_last_r  <= (idx_r + 1'b1 == cnt_r);
            idx_r       <= idx_r + 1'b1;
            if (idx_r + 1'b1 == cnt_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ESTM_ASSERT_NOW(a_used_bound, 1'b1, used_r <= UW'(NODES))
  `ESTM_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LW'(MAX_SEQ + 1))
  `ESTM_ASSERT_NOW(a_emit_index, state_r == S_EMIT, cnt_r != 2'd0 && idx_r < cnt_r)
  `ESTM_ASSERT_NOW(a_match_needs_nodes, matching_r, used_r != '0)
  `ESTM_ASSERT_NEXT(a_grow_room, state_r == S_APP_NEW && used_r == UW'(NODES), 1'b0)

endmodule

@@ src/escape_sequence_trie_matcher.sv @@
// Top level of the escape-sequence trie matcher.
// The matcher takes one beat per input item and, after a short queue, hands it
// to an engine that owns a trie of escape sequences held in a single-port-read
// node memory. A terminal byte is started in the idle state, looks up its
// prefix mark when no match is in progress, reads and compares each node
// visited on the sibling list of the current trie level, and emits its result
// beats; a sequence add reads and compares each node visited on the walk,
// decides in a finish state, writes each new node appended and links it unless
// the trie was empty, and emits its status beat, so the node memory read port
// sets the rate. Add beats and timeouts that produce no result are handled in
// the idle state alone, and output stalls hold the engine in its emit state.
// The input side keeps accepting into a two-entry queue while the engine works
// or while a result beat waits at the output register. After reset the engine
// clears all 256 prefix marks before it takes its first item; the queue may
// fill meanwhile. The node memory needs no clearing pass because every node is
// written before it is linked and read.
module escape_sequence_trie_matcher #(
  parameter int NODES   = estm_pkg::NODES_DEF,
  parameter int MAX_SEQ = estm_pkg::MAX_SEQ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_in [7:0], key_code [23:8]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  input  logic        in_tlast,   // seq_last: final byte of a sequence being added
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value [15:0]
  output logic [1:0]  out_tuser,  // kind [1:0]
  output logic        out_tlast   // last result beat caused by one input beat
);

  // Classified items travel from the front end to the engine as a struct.
  estm_pkg::item_t item;
  logic            item_valid;
  logic            item_ready;

  estm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  // The engine walks and extends the trie and drives the result register.
  estm_back #(
    .NODES   (NODES),
    .MAX_SEQ (MAX_SEQ)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
